@@ rtl/core/lsp_pkg.sv @@
// Shared types and constants of the longitudinal speed controller.
package lsp_pkg;

  localparam int DATA_W   = 16;
  localparam int IDX_W    = 3;
  localparam int GEAR_W   = 3;
  localparam int PCT_W    = 7;
  localparam int MUL_A_W  = 17;
  localparam int MUL_B_W  = 33;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 49;
  localparam int VAL_W    = 57;
  localparam int CMP_W    = 24;
  localparam int DIST_W   = 32;

  localparam logic [IDX_W-1:0] REG_TIME_STEP       = 3'd0;
  localparam logic [IDX_W-1:0] REG_STOP_BRAKE_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_STOP_BRAKE_OFF  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DECEL_GAIN      = 3'd3;
  localparam logic [IDX_W-1:0] REG_SLOPE_PROP_GAIN = 3'd4;
  localparam logic [IDX_W-1:0] REG_SLOPE_INTEG_GAIN = 3'd5;
  localparam logic [IDX_W-1:0] REG_FLAT_PROP_GAIN  = 3'd6;
  localparam logic [IDX_W-1:0] REG_FLAT_INTEG_GAIN = 3'd7;

  localparam logic [DATA_W-1:0] TIME_STEP_RESET = 16'd3277;

  localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 3'd3;
  localparam logic [GEAR_W-1:0] GEAR_REVERSE = 3'd4;

  localparam logic [PCT_W-1:0] THROTTLE_MAX = 7'd100;
  localparam logic [PCT_W-1:0] BRAKE_MAX    = 7'd125;
  localparam int               STOP_BRAKE   = 30;

  typedef struct packed {
    logic load;
    logic mul1;
    logic upd;
    logic mul2;
    logic sum;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/lsp_mul.sv @@
// Shared signed multiplier with a registered product.
module lsp_mul
  import lsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

@@ rtl/core/lsp_ctrl.sv @@
// Sequencer that steps one item through the controller datapath.
module lsp_ctrl
  import lsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_M1;
        end
      end
      S_M1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/lsp_dp.sv @@
// Datapath: configuration registers, controller state, arithmetic and result register.
module lsp_dp
  import lsp_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic signed [DATA_W-1:0] in_target_speed,
  input  logic [DATA_W-1:0]        in_measured_speed,
  input  logic signed [DATA_W-1:0] in_speed_error,
  input  logic signed [DATA_W-1:0] in_pitch_angle,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [GEAR_W-1:0]        out_gear_code,
  output logic [PCT_W-1:0]         out_throttle_percent,
  output logic [PCT_W-1:0]         out_brake_percent
);

  localparam logic signed [CMP_W-1:0] ONE = CMP_W'(1 << FRACTION_BITS);
  localparam logic signed [CMP_W-1:0] TWO = CMP_W'(2 << FRACTION_BITS);
  localparam logic signed [CMP_W-1:0] THREE = CMP_W'(3 << FRACTION_BITS);

  logic [DATA_W-1:0] regs_r [8];

  logic signed [DATA_W-1:0] tgt_r, err_r, pitch_r;
  logic [DATA_W-1:0]        meas_r;
  logic [DIST_W-1:0]        dist_r;
  logic signed [31:0]       integ_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     out_valid_r;
  logic [GEAR_W-1:0]        gear_r;
  logic [PCT_W-1:0]         throttle_r, brake_r;

  logic signed [CMP_W-1:0] tgt_x, err_x, pitch_x, meas_x, mag_x;
  logic                    m_stop, m_slow, m_decel, m_near, m_slope;
  logic                    md_hold, md_dist, md_decel, md_pi;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [DATA_W-1:0]  kp, ki;

  logic signed [32:0]       integ_sum;
  logic signed [31:0]       integ_sat;
  logic [DIST_W:0]          dist_sum;
  logic signed [ACC_W-1:0]  sum_nxt;
  logic signed [VAL_W-1:0]  acc_v, val;
  logic [PCT_W-1:0]         thr_pct, brk_pct;

  function automatic logic [PCT_W-1:0] to_pct(input logic signed [VAL_W-1:0] v,
                                               input logic [PCT_W-1:0] lim);
    logic [VAL_W-1:0] q;
    q = VAL_W'(v) >> (2 * FRACTION_BITS);
    if (v <= 0) begin
      return '0;
    end else if (q > VAL_W'(lim)) begin
      return lim;
    end else begin
      return q[PCT_W-1:0];
    end
  endfunction

  // Threshold decisions are exact integer compares on the latched item.
  always_comb begin
    tgt_x   = CMP_W'(tgt_r);
    err_x   = CMP_W'(err_r);
    pitch_x = CMP_W'(pitch_r);
    meas_x  = CMP_W'({1'b0, meas_r});
    mag_x   = (err_x < 0) ? -err_x : err_x;
    m_stop  = ((tgt_x <<< 4) + (tgt_x <<< 2)) < ONE;
    m_slow  = ((meas_x <<< 3) + (meas_x <<< 1)) < ONE;
    m_decel = (err_x <<< 1) < -ONE;
    m_near  = (mag_x <<< 1) < THREE;
    m_slope = pitch_x > TWO;
    md_hold  = m_stop && m_slow;
    md_dist  = m_stop && !m_slow;
    md_decel = !m_stop && m_decel;
    md_pi    = !m_stop && !m_decel;
  end

  always_comb begin
    kp = m_slope ? signed'(regs_r[REG_SLOPE_PROP_GAIN]) : signed'(regs_r[REG_FLAT_PROP_GAIN]);
    ki = m_slope ? signed'(regs_r[REG_SLOPE_INTEG_GAIN]) : signed'(regs_r[REG_FLAT_INTEG_GAIN]);
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul1) begin
      if (m_stop) begin
        mul_a = signed'({1'b0, meas_r});
        mul_b = signed'(MUL_B_W'(regs_r[REG_TIME_STEP]));
      end else if (m_decel) begin
        mul_a = MUL_A_W'(err_r);
        mul_b = MUL_B_W'(signed'(regs_r[REG_DECEL_GAIN]));
      end else begin
        mul_a = MUL_A_W'(kp);
        mul_b = MUL_B_W'(err_r);
      end
    end else begin
      if (m_stop) begin
        mul_a = MUL_A_W'(signed'(regs_r[REG_STOP_BRAKE_GAIN]));
        mul_b = signed'({1'b0, dist_r});
      end else begin
        mul_a = MUL_A_W'(ki);
        mul_b = MUL_B_W'(integ_r);
      end
    end
  end

  lsp_mul u_mul (
    .clk   (clk),
    .en    (cmd.mul1 | cmd.mul2),
    .a     (mul_a),
    .b     (mul_b),
    .prod_r(prod_r)
  );

  always_comb begin
    integ_sum = 33'(integ_r) + 33'(err_r);
    if (integ_sum[32] != integ_sum[31]) begin
      integ_sat = integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      integ_sat = integ_sum[31:0];
    end
    dist_sum = {1'b0, dist_r} + (DIST_W + 1)'(prod_r[31:16]);
  end

  always_comb begin
    if (md_hold) begin
      sum_nxt = ACC_W'(STOP_BRAKE) <<< (2 * FRACTION_BITS);
    end else if (md_dist) begin
      sum_nxt = prod_r[ACC_W-1:0]
              + (ACC_W'(signed'(regs_r[REG_STOP_BRAKE_OFF])) <<< FRACTION_BITS);
    end else if (md_decel) begin
      sum_nxt = acc_r;
    end else begin
      sum_nxt = acc_r + prod_r[ACC_W-1:0];
    end
  end

  always_comb begin
    acc_v = VAL_W'(acc_r);
    val   = md_pi ? ((acc_v <<< 6) + (acc_v <<< 5) + (acc_v <<< 2)) : acc_v;
    thr_pct = md_pi ? to_pct(val, THROTTLE_MAX) : '0;
    brk_pct = md_pi ? to_pct(-val, BRAKE_MAX) : to_pct(val, BRAKE_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= '0;
      end
      regs_r[REG_TIME_STEP] <= TIME_STEP_RESET;
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r   <= in_target_speed;
      meas_r  <= in_measured_speed;
      err_r   <= in_speed_error;
      pitch_r <= in_pitch_angle;
    end
    if (cmd.upd) begin
      acc_r <= prod_r[ACC_W-1:0];
    end else if (cmd.sum) begin
      acc_r <= sum_nxt;
    end
    if (cmd.out_load) begin
      gear_r     <= (tgt_r < 0) ? GEAR_REVERSE : GEAR_DRIVE;
      throttle_r <= thr_pct;
      brake_r    <= brk_pct;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r      <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mul1 && md_pi) begin
        integ_r <= m_near ? integ_sat : '0;
      end
      if (cmd.upd) begin
        if (md_dist) begin
          dist_r <= dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
        end else if (!m_stop) begin
          dist_r <= '0;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_free      = !out_valid_r || !out_stall;
  assign out_valid            = out_valid_r;
  assign out_gear_code        = gear_r;
  assign out_throttle_percent = throttle_r;
  assign out_brake_percent    = brake_r;

endmodule

@@ rtl/core/longitudinal_speed_pid.sv @@
// Top level of the longitudinal speed controller.
//
// One item per control tick enters on the in_ channel: reference speed, measured
// speed, speed error and pitch, with FRACTION_BITS fraction bits. Each item gives
// exactly one result item on the out_ channel: gear code, throttle and brake percent.
// An item is taken when valid is high and stall is low on that channel.
// The block works on one item at a time with a single shared 17 by 33 bit
// multiplier, which each item uses twice. After acceptance an item passes through
// the states S_M1, S_UPD, S_M2, S_SUM and S_OUT before out_valid rises, and in_stall
// stays high until it is back in idle, so a new item is taken only once the last is loaded.
// The finished result sits in an output register; while the receiver stalls it is
// held unchanged, and a later item waits in its last step until the register frees.
// The configuration port writes one of eight registers per cycle with cfg_we.
// Synchronous reset clears the stop distance and the error integral, restores the
// register defaults and empties the output register.
module longitudinal_speed_pid
  import lsp_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_target_speed,
  input  logic [DATA_W-1:0]        in_measured_speed,
  input  logic signed [DATA_W-1:0] in_speed_error,
  input  logic signed [DATA_W-1:0] in_pitch_angle,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [GEAR_W-1:0]        out_gear_code,
  output logic [PCT_W-1:0]         out_throttle_percent,
  output logic [PCT_W-1:0]         out_brake_percent
);

  cmd_t    cmd;
  status_t status;

  lsp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  lsp_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_target_speed     (in_target_speed),
    .in_measured_speed   (in_measured_speed),
    .in_speed_error      (in_speed_error),
    .in_pitch_angle      (in_pitch_angle),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_gear_code       (out_gear_code),
    .out_throttle_percent(out_throttle_percent),
    .out_brake_percent   (out_brake_percent)
  );

endmodule

@@ rtl/core/lsp_checker.sv @@
// Port-level checks of the longitudinal speed controller and their binding.
module lsp_checker
  import lsp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [GEAR_W-1:0] out_gear_code,
  input logic [PCT_W-1:0]  out_throttle_percent,
  input logic [PCT_W-1:0]  out_brake_percent
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("item accepted while another is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_gear_code)
      && $stable(out_throttle_percent) && $stable(out_brake_percent)))
    else $error("stalled result changed");

  a_gear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gear_code == GEAR_DRIVE || out_gear_code == GEAR_REVERSE))
    else $error("bad gear code");

  a_limits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_throttle_percent <= THROTTLE_MAX && out_brake_percent <= BRAKE_MAX))
    else $error("command out of range");

  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_throttle_percent == '0 || out_brake_percent == '0))
    else $error("throttle and brake both applied");

endmodule

bind longitudinal_speed_pid lsp_checker u_lsp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_gear_code       (out_gear_code),
  .out_throttle_percent(out_throttle_percent),
  .out_brake_percent   (out_brake_percent)
);
